// ----- rtl/tfms_pkg.sv -----
// types, constants and register indexes shared by the flight mission sequencer
// no dependencies

package tfms_pkg;

    localparam int TIMER_BITS = 24;

    localparam int TICK_W  = 8;
    localparam int SW_W    = 10;
    localparam int DUR_W   = 16;
    localparam int SPEED_W = 8;
    localparam int VEL_W   = 9;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 32;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TAKEOFF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOVER_TAKEOFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEG_DURATION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_HOVER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAND_SETTLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEG_SPEED = 3'd5;

    localparam logic [DUR_W-1:0]   RST_WAIT_TAKEOFF  = 16'd2000;
    localparam logic [DUR_W-1:0]   RST_HOVER_TAKEOFF = 16'd6000;
    localparam logic [DUR_W-1:0]   RST_LEG_DURATION  = 16'd3000;
    localparam logic [DUR_W-1:0]   RST_FINAL_HOVER   = 16'd4000;
    localparam logic [DUR_W-1:0]   RST_LAND_SETTLE   = 16'd4000;
    localparam logic [SPEED_W-1:0] RST_LEG_SPEED     = 8'd25;

    typedef enum logic [3:0] {
        STG_ARM         = 4'd0,
        STG_WAIT        = 4'd1,
        STG_HOVER       = 4'd2,
        STG_LEG_FWD     = 4'd3,
        STG_LEG_LEFT    = 4'd4,
        STG_LEG_BACK    = 4'd5,
        STG_LEG_RIGHT   = 4'd6,
        STG_FINAL_HOVER = 4'd7,
        STG_SETTLE      = 4'd8
    } t_stage;

    typedef struct packed {
        logic [DUR_W-1:0]   wait_takeoff;
        logic [DUR_W-1:0]   hover_takeoff;
        logic [DUR_W-1:0]   leg_duration;
        logic [DUR_W-1:0]   final_hover;
        logic [DUR_W-1:0]   land_settle;
        logic [SPEED_W-1:0] leg_speed;
    } t_cfg;

    typedef struct packed {
        logic [3:0]            stage;
        logic                  seen_low;
        logic                  started;
        logic                  takeoff_sent;
        logic [TIMER_BITS-1:0] timer;
    } t_mission;

    typedef struct packed {
        logic [TICK_W-1:0]      tick_ms;
        logic signed [SW_W-1:0] start_switch;
        logic signed [SW_W-1:0] kill_switch;
        logic                   takeoff_ready;
    } t_tick;

    typedef struct packed {
        logic [3:0]              stage_now;
        logic                    mission_started;
        logic signed [VEL_W-1:0] vel_forward;
        logic signed [VEL_W-1:0] vel_side;
        logic                    vel_write;
        logic                    takeoff_pulse;
        logic                    land_pulse;
    } t_result;

endpackage

// ----- rtl/tfms_cfg_regs.sv -----
// configuration register file of the flight mission sequencer
// depends on tfms_pkg

module tfms_cfg_regs
    import tfms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DUR_W-1:0]     i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wait_takeoff  <= RST_WAIT_TAKEOFF;
            r_cfg.hover_takeoff <= RST_HOVER_TAKEOFF;
            r_cfg.leg_duration  <= RST_LEG_DURATION;
            r_cfg.final_hover   <= RST_FINAL_HOVER;
            r_cfg.land_settle   <= RST_LAND_SETTLE;
            r_cfg.leg_speed     <= RST_LEG_SPEED;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WAIT_TAKEOFF:  r_cfg.wait_takeoff  <= i_cfg_wdata;
                CFG_HOVER_TAKEOFF: r_cfg.hover_takeoff <= i_cfg_wdata;
                CFG_LEG_DURATION:  r_cfg.leg_duration  <= i_cfg_wdata;
                CFG_FINAL_HOVER:   r_cfg.final_hover   <= i_cfg_wdata;
                CFG_LAND_SETTLE:   r_cfg.land_settle   <= i_cfg_wdata;
                CFG_LEG_SPEED:     r_cfg.leg_speed     <= i_cfg_wdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/tfms_step_logic.sv -----
// next mission state and command outputs for one tick
// depends on tfms_pkg

module tfms_step_logic
    import tfms_pkg::*;
(
    input  t_cfg     i_cfg,
    input  t_mission i_state,
    input  t_tick    i_tick,
    output t_mission o_state,
    output t_result  o_result
);

    localparam logic [TIMER_BITS-1:0] TimerMax = {TIMER_BITS{1'b1}};

    logic [TIMER_BITS:0]     timer_sum;
    logic [TIMER_BITS-1:0]   timer_sat;
    logic signed [VEL_W-1:0] spd;
    logic                    start_low;
    logic                    start_high;
    logic                    kill;
    t_mission                n_state;
    t_result                 res;

    always_comb begin
        timer_sum  = {1'b0, i_state.timer} + {{(TIMER_BITS + 1 - TICK_W){1'b0}}, i_tick.tick_ms};
        timer_sat  = timer_sum[TIMER_BITS] ? TimerMax : timer_sum[TIMER_BITS-1:0];
        spd        = $signed({1'b0, i_cfg.leg_speed});
        start_low  = i_tick.start_switch[SW_W-1];
        start_high = !i_tick.start_switch[SW_W-1] && (|i_tick.start_switch);
        kill       = !i_tick.kill_switch[SW_W-1] && (|i_tick.kill_switch);

        n_state       = i_state;
        n_state.timer = timer_sat;
        res           = '0;

        case (i_state.stage)
            STG_ARM: begin
                if (start_low) n_state.seen_low = 1'b1;
                if (n_state.seen_low && start_high) begin
                    n_state.started = 1'b1;
                    n_state.stage   = STG_WAIT;
                    n_state.timer   = '0;
                end
            end
            STG_WAIT: begin
                if (timer_sat >= {{(TIMER_BITS-DUR_W){1'b0}}, i_cfg.wait_takeoff}) begin
                    if (i_tick.takeoff_ready && !i_state.takeoff_sent) begin
                        n_state.takeoff_sent = 1'b1;
                        res.takeoff_pulse    = 1'b1;
                    end
                    n_state.stage = STG_HOVER;
                    n_state.timer = '0;
                end
            end
            STG_HOVER: begin
                res.vel_write = 1'b1;
                if (timer_sat >= {{(TIMER_BITS-DUR_W){1'b0}}, i_cfg.hover_takeoff}) begin
                    n_state.stage = STG_LEG_FWD;
                    n_state.timer = '0;
                end
            end
            STG_LEG_FWD, STG_LEG_LEFT, STG_LEG_BACK, STG_LEG_RIGHT: begin
                res.vel_write = 1'b1;
                if (timer_sat < {{(TIMER_BITS-DUR_W){1'b0}}, i_cfg.leg_duration}) begin
                    case (i_state.stage)
                        STG_LEG_FWD:  res.vel_forward = spd;
                        STG_LEG_LEFT: res.vel_side    = -spd;
                        STG_LEG_BACK: res.vel_forward = -spd;
                        default:      res.vel_side    = spd;
                    endcase
                end else begin
                    // leg ends with a zero velocity command
                    n_state.stage = i_state.stage + 4'd1;
                    n_state.timer = '0;
                end
            end
            STG_FINAL_HOVER: begin
                res.vel_write = 1'b1;
                if (timer_sat >= {{(TIMER_BITS-DUR_W){1'b0}}, i_cfg.final_hover}) begin
                    res.land_pulse = 1'b1;
                    n_state.stage  = STG_SETTLE;
                    n_state.timer  = '0;
                end
            end
            STG_SETTLE: begin
                res.vel_write = 1'b1;
                if (timer_sat >= {{(TIMER_BITS-DUR_W){1'b0}}, i_cfg.land_settle}) begin
                    n_state = '0;
                end
            end
            default: begin
                res.vel_write = 1'b1;
                n_state       = '0;
            end
        endcase

        // abort overrides the stage result, keeping any takeoff pulse
        if (kill) begin
            res.vel_forward = '0;
            res.vel_side    = '0;
            res.vel_write   = 1'b1;
            res.land_pulse  = 1'b1;
            n_state         = '0;
        end

        res.stage_now       = n_state.stage;
        res.mission_started = n_state.started;
    end

    assign o_state  = n_state;
    assign o_result = res;

endmodule

// ----- rtl/timed_flight_mission_sequencer.sv -----
// Timed flight mission sequencer, top level: input register, step logic, result register.
// A tick transfer loads the input register; the result of the combinational step logic
// then goes to the result register, waiting while that register is full and not drained.
// Throughput: one tick per cycle while m_axis_tready keeps the result register draining.
// Reset (i_rst_n low, synchronous) clears the mission state and the pipeline valids
// and loads the default timings; no clearing pass.
// depends on tfms_pkg, tfms_cfg_regs and tfms_step_logic

module timed_flight_mission_sequencer
    import tfms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // tick_ms[7:0], start_switch[17:8], kill_switch[27:18], takeoff_ready[28], zero fill
    input  logic [IN_W-1:0]      s_axis_tdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // stage_now[3:0], mission_started[4], vel_forward[13:5], vel_side[22:14],
    // vel_write[23], takeoff_pulse[24], land_pulse[25], zero fill
    output logic [OUT_W-1:0]     m_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DUR_W-1:0]     i_cfg_wdata
);

    t_cfg     cfg;
    t_tick    r_tick;
    logic     r_in_valid;
    t_mission r_state;
    t_mission n_state;
    t_result  step_res;
    t_result  r_res;
    logic     r_out_valid;
    logic     advance;

    tfms_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    tfms_step_logic u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_tick   (r_tick),
        .o_state  (n_state),
        .o_result (step_res)
    );

    // the registered tick moves on whenever the result register is free or being drained
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_tick.tick_ms       <= s_axis_tdata[7:0];
            r_tick.start_switch  <= s_axis_tdata[17:8];
            r_tick.kill_switch   <= s_axis_tdata[27:18];
            r_tick.takeoff_ready <= s_axis_tdata[28];
        end
        if (advance) r_res <= step_res;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_res.land_pulse, r_res.takeoff_pulse, r_res.vel_write,
                            r_res.vel_side, r_res.vel_forward, r_res.mission_started,
                            r_res.stage_now};

endmodule

// ----- test/tfms_sb_pkg.sv -----
// scoreboard for the flight mission sequencer testbench: a tick-by-tick mission
// predictor with its own copy of the timings, and a queue of the commands it expects
// depends on tfms_pkg

package tfms_sb_pkg;
    import tfms_pkg::*;

    class mission_scoreboard;
        t_cfg                  cfg;
        logic [3:0]            stage;
        logic                  seen_low;
        logic                  started;
        logic                  takeoff_sent;
        logic [TIMER_BITS-1:0] stage_ms;
        t_result               cmd_q[$];
        int                    errors;

        function new();
            cfg.wait_takeoff  = RST_WAIT_TAKEOFF;
            cfg.hover_takeoff = RST_HOVER_TAKEOFF;
            cfg.leg_duration  = RST_LEG_DURATION;
            cfg.final_hover   = RST_FINAL_HOVER;
            cfg.land_settle   = RST_LAND_SETTLE;
            cfg.leg_speed     = RST_LEG_SPEED;
            errors = 0;
            disarm();
        endfunction

        function void disarm();
            stage        = STG_ARM;
            seen_low     = 1'b0;
            started      = 1'b0;
            takeoff_sent = 1'b0;
            stage_ms     = '0;
        endfunction

        function void enter_stage(logic [3:0] s);
            stage    = s;
            stage_ms = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] val);
            case (idx)
                CFG_WAIT_TAKEOFF:  cfg.wait_takeoff  = val;
                CFG_HOVER_TAKEOFF: cfg.hover_takeoff = val;
                CFG_LEG_DURATION:  cfg.leg_duration  = val;
                CFG_FINAL_HOVER:   cfg.final_hover   = val;
                CFG_LAND_SETTLE:   cfg.land_settle   = val;
                CFG_LEG_SPEED:     cfg.leg_speed     = val[SPEED_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return cmd_q.size();
        endfunction

        // widen a 16-bit duration to the timer width
        function logic [TIMER_BITS-1:0] dur(logic [DUR_W-1:0] d);
            return {{(TIMER_BITS-DUR_W){1'b0}}, d};
        endfunction

        // advance the mission by one accepted tick and queue the command it yields
        function void fly_tick(t_tick t);
            t_result                 r;
            logic [TIMER_BITS:0]     sum;
            logic signed [VEL_W-1:0] spd;
            r   = '0;
            spd = {1'b0, cfg.leg_speed};
            sum = {1'b0, stage_ms} + {{(TIMER_BITS+1-TICK_W){1'b0}}, t.tick_ms};
            stage_ms = sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : sum[TIMER_BITS-1:0];

            case (stage)
                STG_ARM: begin
                    if ($signed(t.start_switch) < 0)
                        seen_low = 1'b1;
                    if (seen_low && $signed(t.start_switch) > 0) begin
                        started = 1'b1;
                        enter_stage(STG_WAIT);
                    end
                end
                STG_WAIT: begin
                    if (stage_ms >= dur(cfg.wait_takeoff)) begin
                        // no pulse when the autopilot is not ready, but move on anyway
                        if (t.takeoff_ready && !takeoff_sent) begin
                            takeoff_sent    = 1'b1;
                            r.takeoff_pulse = 1'b1;
                        end
                        enter_stage(STG_HOVER);
                    end
                end
                STG_HOVER: begin
                    r.vel_write = 1'b1;
                    if (stage_ms >= dur(cfg.hover_takeoff))
                        enter_stage(STG_LEG_FWD);
                end
                STG_LEG_FWD, STG_LEG_LEFT, STG_LEG_BACK, STG_LEG_RIGHT: begin
                    r.vel_write = 1'b1;
                    if (stage_ms < dur(cfg.leg_duration)) begin
                        if (stage == STG_LEG_FWD)
                            r.vel_forward = spd;
                        else if (stage == STG_LEG_LEFT)
                            r.vel_side = -spd;
                        else if (stage == STG_LEG_BACK)
                            r.vel_forward = -spd;
                        else
                            r.vel_side = spd;
                    end else begin
                        // leg end: zero velocity written
                        enter_stage(stage + 4'd1);
                    end
                end
                STG_FINAL_HOVER: begin
                    r.vel_write = 1'b1;
                    if (stage_ms >= dur(cfg.final_hover)) begin
                        r.land_pulse = 1'b1;
                        enter_stage(STG_SETTLE);
                    end
                end
                STG_SETTLE: begin
                    r.vel_write = 1'b1;
                    if (stage_ms >= dur(cfg.land_settle))
                        disarm();
                end
                default: begin
                    r.vel_write = 1'b1;
                    disarm();
                end
            endcase

            // kill switch overrides the stage outcome but keeps a takeoff pulse
            if ($signed(t.kill_switch) > 0) begin
                r.vel_forward = '0;
                r.vel_side    = '0;
                r.vel_write   = 1'b1;
                r.land_pulse  = 1'b1;
                disarm();
            end

            r.stage_now       = stage;
            r.mission_started = started;
            cmd_q.push_back(r);
        endfunction

        function void field_ok(string nm, int want, int got);
            if (want != got) begin
                $display("%0t mismatch %s expected %0d actual %0d", $time, nm, want, got);
                errors++;
            end
        endfunction

        function void check_cmd(t_result got);
            t_result want;
            if (cmd_q.size() == 0) begin
                $display("%0t unexpected result expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = cmd_q.pop_front();
            field_ok("stage_now", want.stage_now, got.stage_now);
            field_ok("mission_started", want.mission_started, got.mission_started);
            field_ok("vel_forward", $signed(want.vel_forward), $signed(got.vel_forward));
            field_ok("vel_side", $signed(want.vel_side), $signed(got.vel_side));
            field_ok("vel_write", want.vel_write, got.vel_write);
            field_ok("takeoff_pulse", want.takeoff_pulse, got.takeoff_pulse);
            field_ok("land_pulse", want.land_pulse, got.land_pulse);
        endfunction
    endclass

endpackage

// ----- test/tb_top.sv -----
// top of the flight mission sequencer testbench: clock, reset, stream drivers,
// register writes, directed and random tick phases, watchdog and final verdict
// depends on tfms_pkg, tfms_sb_pkg and timed_flight_mission_sequencer

module tb_top;
    import tfms_pkg::*;
    import tfms_sb_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic [IN_W-1:0]      s_tdata   = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DUR_W-1:0]     cfg_wdata = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_cycles = 0;

    mission_scoreboard sb = new();

    always #6 clk = ~clk;

    timed_flight_mission_sequencer u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tdata  (s_tdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata)
    );

    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // both sides sampled at the edge, before any of this step's updates land
    always @(posedge clk) begin : monitor
        t_tick   tk_in;
        t_result res;
        if (rst_n && s_tvalid && s_tready) begin
            tk_in.tick_ms       = s_tdata[7:0];
            tk_in.start_switch  = s_tdata[17:8];
            tk_in.kill_switch   = s_tdata[27:18];
            tk_in.takeoff_ready = s_tdata[28];
            sb.fly_tick(tk_in);
        end
        if (rst_n && m_tvalid && m_tready) begin
            res.stage_now       = m_tdata[3:0];
            res.mission_started = m_tdata[4];
            res.vel_forward     = m_tdata[13:5];
            res.vel_side        = m_tdata[22:14];
            res.vel_write       = m_tdata[23];
            res.takeoff_pulse   = m_tdata[24];
            res.land_pulse      = m_tdata[25];
            sb.check_cmd(res);
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL timed_flight_mission_sequencer");
            $finish;
        end
    end

    task automatic send_tick(input t_tick t);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, t.takeoff_ready, t.kill_switch, t.start_switch, t.tick_ms};
        do @(posedge clk); while (!s_tready);
    endtask

    // hold the sender until every queued command has come back, then settle;
    // the monitor first notes the last transfer before the queue is checked
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic load_cfg(input logic [DUR_W-1:0] w, h, l, f, s,
                            input logic [SPEED_W-1:0] spd);
        write_reg(CFG_WAIT_TAKEOFF, w);
        write_reg(CFG_HOVER_TAKEOFF, h);
        write_reg(CFG_LEG_DURATION, l);
        write_reg(CFG_FINAL_HOVER, f);
        write_reg(CFG_LAND_SETTLE, s);
        write_reg(CFG_LEG_SPEED, {{(DUR_W-SPEED_W){1'b0}}, spd});
    endtask

    function automatic t_tick tk(int tick, int start, int kill, bit ready);
        t_tick t;
        t.tick_ms       = tick[TICK_W-1:0];
        t.start_switch  = start[SW_W-1:0];
        t.kill_switch   = kill[SW_W-1:0];
        t.takeoff_ready = ready;
        return t;
    endfunction

    // switch toggles low and high often so missions arm quickly; kills are rare
    function automatic t_tick rand_tick(int kill_pm, int tick_lo);
        int start_v;
        int kill_v;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            start_v = -int'($urandom_range(1, 512));
        else if (pick < 90)
            start_v = $urandom_range(1, 511);
        else
            start_v = 0;
        if ($urandom_range(0, 999) < kill_pm)
            kill_v = $urandom_range(1, 511);
        else
            kill_v = -int'($urandom_range(0, 512));
        return tk($urandom_range(tick_lo, 255), start_v, kill_v,
                  $urandom_range(0, 99) < 85);
    endfunction

    task automatic run_phase(input logic [DUR_W-1:0] w, h, l, f, s,
                             input logic [SPEED_W-1:0] spd,
                             input int n_ticks, input int kill_pm, input int tick_lo);
        wait_idle();
        load_cfg(w, h, l, f, s, spd);
        repeat (n_ticks)
            send_tick(rand_tick(kill_pm, tick_lo));
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 17;
        rx_idle_pct = 80;

        // directed: short timings so a whole mission fits in a handful of ticks
        wait_idle();
        load_cfg(16'd255, 16'd0, 16'd0, 16'd256, 16'd1, 8'd255);
        send_tick(tk(0, 511, -512, 1));     // high before low: no start
        send_tick(tk(255, 0, 0, 1));
        send_tick(tk(255, -512, -1, 0));    // switch seen low
        send_tick(tk(0, 0, 0, 0));
        send_tick(tk(1, 1, 0, 1));          // start
        send_tick(tk(254, 0, 0, 0));
        send_tick(tk(1, 0, 0, 0));          // wait over, autopilot not ready
        send_tick(tk(0, 0, 0, 1));          // zero hover
        send_tick(tk(0, 0, 0, 1));          // zero-length legs
        send_tick(tk(0, 0, 0, 1));
        send_tick(tk(0, 0, 0, 1));
        send_tick(tk(0, 0, 0, 1));
        send_tick(tk(255, 0, 0, 1));
        send_tick(tk(1, 0, 0, 1));          // land pulse
        send_tick(tk(0, 0, 0, 1));
        send_tick(tk(1, 0, 0, 1));          // settle over, mission ends
        send_tick(tk(255, -1, 0, 1));
        send_tick(tk(255, 511, 0, 1));
        send_tick(tk(255, 0, 0, 1));        // takeoff pulse
        send_tick(tk(0, 0, 511, 1));        // kill during hover
        send_tick(tk(0, -1, 0, 1));
        send_tick(tk(0, 1, 0, 1));
        send_tick(tk(255, 0, 1, 1));        // takeoff and kill in the same tick

        run_phase(16'd2000, 16'd6000, 16'd3000, 16'd4000, 16'd4000, 8'd25, 250, 2, 0);
        run_phase(16'd500, 16'd300, 16'd400, 16'd200, 16'd300, 8'd100, 250, 5, 0);

        tx_idle_pct = 80;
        rx_idle_pct = 17;
        run_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 100, 5, 0);
        run_phase(16'd65535, 16'd1, 16'd512, 16'd255, 16'd2, 8'd255, 350, 1, 200);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(16'd50, 16'd60, 16'd70, 16'd80, 16'd90, 8'd128, 200, 150, 0);
        run_phase(16'd1000, 16'd700, 16'd900, 16'd600, 16'd800, 8'd200, 100, 3, 0);

        wait_idle();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS timed_flight_mission_sequencer");
        else
            $display("FAIL timed_flight_mission_sequencer");
        $finish;
    end

endmodule
